// ----- rtl/ljsm_pkg.sv -----
// shared constants and control/status types for the latency/jitter statistics monitor
// no dependencies; used by every module of the block by scoped names
`default_nettype none

package ljsm_pkg;

  // width of the free running timestamps that latency is taken modulo
  localparam int unsigned TimeWidth = 32;

  // width of every statistic and field
  localparam int unsigned DataW = 32;

  // latency is kept to 32 bits after wrapping modulo 2^TimeWidth
  localparam logic [DataW-1:0] LatMask =
    (TimeWidth >= DataW) ? {DataW{1'b1}} : DataW'((64'd1 << TimeWidth) - 64'd1);

  // one quotient bit per step in the serial divider
  localparam int unsigned DivSteps = DataW;
  localparam int unsigned DivCntW  = $clog2(DivSteps + 1);

  // selects which average the divider works on
  localparam logic DivSelLat = 1'b0;
  localparam logic DivSelJit = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;    // take the input item, form latency
    logic calc_jit;   // form jitter and sequence gap
    logic update;     // fold the item into the running statistics
    logic div_start;  // launch the shared divider
    logic div_sel;    // operands for the divider
    logic store_lat;  // keep quotient as average latency
    logic store_jit;  // keep quotient as average jitter
    logic load_out;   // copy the result into the output register
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic div_done;   // quotient ready this cycle
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/ljsm_div.sv -----
// serial restoring divider, one quotient bit per cycle
// depends on ljsm_pkg for widths
`default_nettype none

module ljsm_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [ljsm_pkg::DataW-1:0] dividend_i,
  input  wire logic [ljsm_pkg::DataW-1:0] divisor_i,
  output logic                            done_o,
  output logic [ljsm_pkg::DataW-1:0]      quotient_o
);

  logic [ljsm_pkg::DataW-1:0]   rem_q, rem_d;
  logic [ljsm_pkg::DataW-1:0]   quo_q, quo_d;
  logic [ljsm_pkg::DataW-1:0]   dsr_q, dsr_d;
  logic [ljsm_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic                         done_q, done_d;
  logic [ljsm_pkg::DataW:0]     trial;

  // partial remainder shifted left with the next dividend bit, minus divisor
  assign trial = {rem_q, quo_q[ljsm_pkg::DataW-1]} - {1'b0, dsr_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      dsr_d = divisor_i;
      cnt_d = ljsm_pkg::DivCntW'(ljsm_pkg::DivSteps);
    end else if (cnt_q != '0) begin
      if (!trial[ljsm_pkg::DataW]) begin
        rem_d = trial[ljsm_pkg::DataW-1:0];
        quo_d = {quo_q[ljsm_pkg::DataW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[ljsm_pkg::DataW-2:0], quo_q[ljsm_pkg::DataW-1]};
        quo_d = {quo_q[ljsm_pkg::DataW-2:0], 1'b0};
      end
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == ljsm_pkg::DivCntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ----- rtl/ljsm_dp.sv -----
// datapath: latency, jitter and loss arithmetic, running statistics, output register
// depends on ljsm_pkg and ljsm_div
`default_nettype none

module ljsm_dp (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire ljsm_pkg::cmd_t               cmd_i,
  output ljsm_pkg::sts_t                    sts_o,
  input  wire logic [ljsm_pkg::DataW-1:0]   rx_time_i,
  input  wire logic [ljsm_pkg::DataW-1:0]   tx_time_i,
  input  wire logic [ljsm_pkg::DataW-1:0]   seq_num_i,
  output logic [10*ljsm_pkg::DataW-1:0]     result_o
);

  localparam int unsigned W = ljsm_pkg::DataW;

  // current item
  logic [W-1:0] seq_q, lat_q, jit_q, gap_q;
  logic         first_q;

  // running statistics
  logic [W-1:0] lat_min_q, lat_max_q, lat_sum_q, rx_count_q, prev_lat_q;
  logic [W-1:0] jit_sum_q, jit_max_q, lost_acc_q, last_seq_q;
  logic [W-1:0] avg_lat_q, avg_jit_q;
  logic [10*W-1:0] out_q;

  logic [W-1:0] lat_next, jit_next, div_a, div_b, quo;
  logic         div_done;

  assign lat_next = (rx_time_i - tx_time_i) & ljsm_pkg::LatMask;
  assign jit_next = (lat_q > prev_lat_q) ? (lat_q - prev_lat_q) : (prev_lat_q - lat_q);

  always_comb begin
    unique case (cmd_i.div_sel)
      ljsm_pkg::DivSelLat: begin
        div_a = lat_sum_q;
        div_b = rx_count_q;
      end
      ljsm_pkg::DivSelJit: begin
        div_a = jit_sum_q;
        div_b = rx_count_q - 1'b1;
      end
      default: begin
        div_a = lat_sum_q;
        div_b = rx_count_q;
      end
    endcase
  end

  ljsm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  assign sts_o.div_done = div_done;

  // item payload, averages and output register, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      seq_q <= seq_num_i;
      lat_q <= lat_next;
    end
    if (cmd_i.calc_jit) begin
      first_q <= (rx_count_q == '0);
      jit_q   <= (rx_count_q == '0) ? '0 : jit_next;
      gap_q   <= seq_q - last_seq_q - 1'b1;
    end
    if (cmd_i.store_lat) begin
      avg_lat_q <= (rx_count_q != '0) ? quo : '0;
    end
    if (cmd_i.store_jit) begin
      avg_jit_q <= (rx_count_q > W'(1)) ? quo : '0;
    end
    if (cmd_i.load_out) begin
      out_q <= {rx_count_q, lost_acc_q, jit_max_q, avg_jit_q, avg_lat_q,
                lat_max_q, lat_min_q, jit_q, lat_q, seq_q};
    end
  end

  // statistics state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_min_q  <= '1;
      lat_max_q  <= '0;
      lat_sum_q  <= '0;
      rx_count_q <= '0;
      prev_lat_q <= '0;
      jit_sum_q  <= '0;
      jit_max_q  <= '0;
      lost_acc_q <= '0;
      last_seq_q <= '0;
    end else if (cmd_i.update) begin
      if (!first_q) begin
        lost_acc_q <= lost_acc_q + gap_q;
        jit_sum_q  <= jit_sum_q + jit_q;
        if (jit_q > jit_max_q) begin
          jit_max_q <= jit_q;
        end
      end
      last_seq_q <= seq_q;
      prev_lat_q <= lat_q;
      rx_count_q <= rx_count_q + 1'b1;
      lat_sum_q  <= lat_sum_q + lat_q;
      if (lat_q < lat_min_q) begin
        lat_min_q <= lat_q;
      end
      if (lat_q > lat_max_q) begin
        lat_max_q <= lat_q;
      end
    end
  end

  assign result_o = out_q;

endmodule

`default_nettype wire

// ----- rtl/ljsm_ctrl.sv -----
// controller: sequences one item through update and the two divisions
// depends on ljsm_pkg for the command and status types
`default_nettype none

module ljsm_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire ljsm_pkg::sts_t sts_i,
  output ljsm_pkg::cmd_t      cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StJit  = 3'd1;
  localparam logic [2:0] StAcc  = 3'd2;
  localparam logic [2:0] StDLat = 3'd3;
  localparam logic [2:0] StWLat = 3'd4;
  localparam logic [2:0] StDJit = 3'd5;
  localparam logic [2:0] StWJit = 3'd6;
  localparam logic [2:0] StEmit = 3'd7;

  logic [2:0] state_q, state_d;
  logic       ovalid_q, ovalid_d;
  logic       out_free;

  assign out_free = !ovalid_q || out_ready_i;

  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    ovalid_d = ovalid_q && !out_ready_i;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StJit;
        end
      end
      StJit: begin
        cmd_o.calc_jit = 1'b1;
        state_d        = StAcc;
      end
      StAcc: begin
        cmd_o.update = 1'b1;
        state_d      = StDLat;
      end
      StDLat: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = ljsm_pkg::DivSelLat;
        state_d         = StWLat;
      end
      StWLat: begin
        if (sts_i.div_done) begin
          cmd_o.store_lat = 1'b1;
          state_d         = StDJit;
        end
      end
      StDJit: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = ljsm_pkg::DivSelJit;
        state_d         = StWJit;
      end
      StWJit: begin
        if (sts_i.div_done) begin
          cmd_o.store_jit = 1'b1;
          state_d         = StEmit;
        end
      end
      StEmit: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          ovalid_d       = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = ovalid_q;

endmodule

`default_nettype wire

// ----- rtl/latency_jitter_stats_monitor_unit.sv -----
// top level of the packet latency / jitter / loss statistics monitor
// depends on ljsm_pkg, ljsm_ctrl, ljsm_dp (which holds ljsm_div)
//
//   channel   dir  handshake                   payload
//   s_axis    in   s_axis_tvalid/tready        tdata 96 bits: rx_time, tx_time, seq_num
//   m_axis    out  m_axis_tvalid/tready        tdata 320 bits: ten 32-bit statistics
//
// after the accepting edge the controller forms jitter and sequence gap, then
// updates the statistics, then runs the shared serial divider twice (start,
// 32 steps, store) for average latency and average jitter, and then loads the
// output register; input ready returns after that load, so a new item is taken
// only once the previous result is in the output register
// reset (rst_ni low, asynchronous) clears the running statistics to their start values
// a finished result waits in the output register while the next item is taken;
// a new result is only loaded once the previous one has been taken
`default_nettype none

module latency_jitter_stats_monitor_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // input items
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [31:0] rx_time, [63:32] tx_time, [95:64] seq_num
  input  wire logic [95:0]  s_axis_tdata,
  // result items
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [31:0] out_seq, [63:32] latency, [95:64] jitter, [127:96] min_latency,
  // [159:128] max_latency, [191:160] mean_latency, [223:192] mean_jitter,
  // [255:224] max_jitter, [287:256] lost_total, [319:288] packet_count
  output logic [319:0]      m_axis_tdata
);

  ljsm_pkg::cmd_t cmd;
  ljsm_pkg::sts_t sts;

  // controller: walks each item through update, both divisions and output load
  ljsm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: arithmetic, statistics registers, divider and output register
  ljsm_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .rx_time_i (s_axis_tdata[31:0]),
    .tx_time_i (s_axis_tdata[63:32]),
    .seq_num_i (s_axis_tdata[95:64]),
    .result_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire
